// ===== sv/ptcu_pkg.sv =====
// Shared types, operation codes and constants of the privileged trap CSR unit.
`default_nettype none

package ptcu_pkg;

    // Architectural word width.
    localparam int XLEN_BITS = 32;
    localparam int DATA_W    = 32;

    // Operation codes.
    localparam logic [2:0] OP_READ        = 3'd0;
    localparam logic [2:0] OP_WRITE       = 3'd1;
    localparam logic [2:0] OP_SET_PENDING = 3'd2;
    localparam logic [2:0] OP_IRQ_CHECK   = 3'd3;
    localparam logic [2:0] OP_EXC_DELEG   = 3'd4;
    localparam logic [2:0] OP_TRAP        = 3'd5;
    localparam logic [2:0] OP_RETURN      = 3'd6;

    // Privilege levels.
    localparam logic [1:0] LV_USER     = 2'd0;
    localparam logic [1:0] LV_SUPER    = 2'd1;
    localparam logic [1:0] LV_RESERVED = 2'd2;
    localparam logic [1:0] LV_MACHINE  = 2'd3;

    // Register banks, one per implemented level.
    localparam int NUM_BANKS = 3;
    localparam logic [1:0] BANK_USER    = 2'd0;
    localparam logic [1:0] BANK_SUPER   = 2'd1;
    localparam logic [1:0] BANK_MACHINE = 2'd2;

    // CSR slot indexes.
    localparam logic [3:0] CSR_STATUS    = 4'd0;
    localparam logic [3:0] CSR_ISA       = 4'd1;
    localparam logic [3:0] CSR_EDELEG    = 4'd2;
    localparam logic [3:0] CSR_IDELEG    = 4'd3;
    localparam logic [3:0] CSR_IE        = 4'd4;
    localparam logic [3:0] CSR_TVEC      = 4'd5;
    localparam logic [3:0] CSR_COUNTEREN = 4'd6;
    localparam logic [3:0] CSR_SCRATCH   = 4'd7;
    localparam logic [3:0] CSR_EPC       = 4'd8;
    localparam logic [3:0] CSR_CAUSE     = 4'd9;
    localparam logic [3:0] CSR_TVAL      = 4'd10;
    localparam logic [3:0] CSR_IP        = 4'd11;

    // Standard bit positions.
    localparam int BIT_MSIP   = 3;
    localparam int BIT_MTIP   = 7;
    localparam int BIT_SEIP   = 9;
    localparam int BIT_MEIP   = 11;
    localparam int BIT_SPP    = 8;
    localparam int BIT_MPP_LO = 11;
    localparam int BIT_MPP_HI = 12;

    // Interrupt gating masks.
    localparam logic [7:0] GATE_BASE  = 8'hF0;
    localparam logic [3:0] SERVE_BASE = 4'hF;

    // Interrupt flag of the cause register; dropped when it lies above the word.
    localparam logic [DATA_W-1:0] CAUSE_INT_BIT = DATA_W'(64'h1 << (XLEN_BITS - 1));

    // Per-level register bank.
    typedef struct packed {
        logic [DATA_W-1:0] isa;
        logic [DATA_W-1:0] edeleg;
        logic [DATA_W-1:0] ideleg;
        logic [DATA_W-1:0] tvec;
        logic [DATA_W-1:0] counteren;
        logic [DATA_W-1:0] scratch;
        logic [DATA_W-1:0] epc;
        logic [DATA_W-1:0] cause;
        logic [DATA_W-1:0] tval;
    } bank_t;

    // Whole architectural state.
    typedef struct packed {
        logic [DATA_W-1:0]          status;
        logic [DATA_W-1:0]          ie;
        logic [DATA_W-1:0]          ip;
        bank_t [NUM_BANKS-1:0]      banks;
    } csr_state_t;

    // One command beat.
    typedef struct packed {
        logic [2:0]        operation;
        logic [1:0]        level;
        logic [1:0]        previous_level;
        logic [3:0]        csr_slot;
        logic [DATA_W-1:0] write_value;
        logic              ext_irq;
        logic              timer_irq;
        logic              sw_irq;
        logic [4:0]        cause_code;
        logic              trap_is_irq;
        logic [DATA_W-1:0] current_pc;
        logic [DATA_W-1:0] trap_value;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic              irq_taken;
        logic [1:0]        level_out;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/ptcu_engine.sv =====
// Combinational execution of one command against the CSR state.
`default_nettype none

module ptcu_engine (
    input  wire ptcu_pkg::csr_state_t state_cur,
    input  wire ptcu_pkg::item_t      item,
    output ptcu_pkg::csr_state_t      state_next,
    output ptcu_pkg::result_t         result
);

    logic                          bank_ok;
    logic [1:0]                    bank_idx;
    ptcu_pkg::bank_t               cur_bank;
    logic [ptcu_pkg::DATA_W-1:0]   sel_bit;
    logic [4:0]                    ie_pos;
    logic [4:0]                    pie_pos;
    logic                          m_ideleg;
    logic                          s_ideleg;
    logic                          u_ideleg;
    logic                          m_edeleg;
    logic                          s_edeleg;
    logic                          serve_ok;
    logic [1:0]                    serve_level;
    logic [7:0]                    gate_wide;
    logic [3:0]                    gate;
    logic [3:0]                    serve_mask;
    logic                          irq_live;
    logic [1:0]                    exc_level;

    // Bank selection; the reserved level has no bank.
    assign bank_ok  = (item.level != ptcu_pkg::LV_RESERVED);
    assign bank_idx = (item.level == ptcu_pkg::LV_MACHINE) ? ptcu_pkg::BANK_MACHINE :
                      (item.level == ptcu_pkg::LV_SUPER)   ? ptcu_pkg::BANK_SUPER :
                                                             ptcu_pkg::BANK_USER;
    assign cur_bank = state_cur.banks[bank_idx];
    assign sel_bit  = ptcu_pkg::DATA_W'(1) << item.cause_code;
    assign ie_pos   = {3'b000, item.level};
    assign pie_pos  = 5'd4 + ie_pos;

    // Delegation bits of each level for the selected cause.
    assign m_ideleg = |(state_cur.banks[ptcu_pkg::BANK_MACHINE].ideleg & sel_bit);
    assign s_ideleg = |(state_cur.banks[ptcu_pkg::BANK_SUPER].ideleg & sel_bit);
    assign u_ideleg = |(state_cur.banks[ptcu_pkg::BANK_USER].ideleg & sel_bit);
    assign m_edeleg = |(state_cur.banks[ptcu_pkg::BANK_MACHINE].edeleg & sel_bit);
    assign s_edeleg = |(state_cur.banks[ptcu_pkg::BANK_SUPER].edeleg & sel_bit);

    // Interrupt delegation walk from machine down to the current level.
    // When every tested level delegates, service falls one level below (none below user).
    always_comb
    begin
        serve_ok    = 1'b1;
        serve_level = ptcu_pkg::LV_MACHINE;
        if (!m_ideleg)
        begin
            serve_level = ptcu_pkg::LV_MACHINE;
        end
        else if (item.level == ptcu_pkg::LV_MACHINE)
        begin
            serve_level = ptcu_pkg::LV_RESERVED;
        end
        else if (!s_ideleg)
        begin
            serve_level = ptcu_pkg::LV_SUPER;
        end
        else if (item.level == ptcu_pkg::LV_SUPER)
        begin
            serve_level = ptcu_pkg::LV_USER;
        end
        else if (!u_ideleg)
        begin
            serve_level = ptcu_pkg::LV_USER;
        end
        else
        begin
            serve_ok = 1'b0;
        end
    end

    // Global enable gating against the serving level.
    assign gate_wide  = ptcu_pkg::GATE_BASE >> (3'd4 - {1'b0, item.level});
    assign gate       = gate_wide[3:0] & state_cur.status[3:0];
    assign serve_mask = serve_ok ? (ptcu_pkg::SERVE_BASE >> (2'd3 - serve_level)) : 4'h0;
    assign irq_live   = bank_ok && (|(state_cur.ip & sel_bit)) && (|(state_cur.ie & sel_bit));

    // Exception delegation saturates at user level.
    assign exc_level = !m_edeleg ? ptcu_pkg::LV_MACHINE :
                       !s_edeleg ? ptcu_pkg::LV_SUPER : ptcu_pkg::LV_USER;

    // Operation decode and state update.
    always_comb
    begin
        state_next = state_cur;
        result     = '0;
        case (item.operation)
            ptcu_pkg::OP_READ:
            begin
                if (bank_ok)
                begin
                    case (item.csr_slot)
                        ptcu_pkg::CSR_STATUS:    result.result_value = state_cur.status;
                        ptcu_pkg::CSR_ISA:       result.result_value = cur_bank.isa;
                        ptcu_pkg::CSR_EDELEG:    result.result_value = cur_bank.edeleg;
                        ptcu_pkg::CSR_IDELEG:    result.result_value = cur_bank.ideleg;
                        ptcu_pkg::CSR_IE:        result.result_value = state_cur.ie;
                        ptcu_pkg::CSR_TVEC:      result.result_value = cur_bank.tvec;
                        ptcu_pkg::CSR_COUNTEREN: result.result_value = cur_bank.counteren;
                        ptcu_pkg::CSR_SCRATCH:   result.result_value = cur_bank.scratch;
                        ptcu_pkg::CSR_EPC:       result.result_value = cur_bank.epc;
                        ptcu_pkg::CSR_CAUSE:     result.result_value = cur_bank.cause;
                        ptcu_pkg::CSR_TVAL:      result.result_value = cur_bank.tval;
                        ptcu_pkg::CSR_IP:        result.result_value = state_cur.ip;
                        default:                 result.result_value = '0;
                    endcase
                end
            end
            ptcu_pkg::OP_WRITE:
            begin
                if (bank_ok)
                begin
                    case (item.csr_slot)
                        ptcu_pkg::CSR_STATUS:    state_next.status = item.write_value;
                        ptcu_pkg::CSR_ISA:
                            state_next.banks[bank_idx].isa = item.write_value;
                        ptcu_pkg::CSR_EDELEG:
                            state_next.banks[bank_idx].edeleg = item.write_value;
                        ptcu_pkg::CSR_IDELEG:
                            state_next.banks[bank_idx].ideleg = item.write_value;
                        ptcu_pkg::CSR_IE:        state_next.ie = item.write_value;
                        ptcu_pkg::CSR_TVEC:
                            state_next.banks[bank_idx].tvec = item.write_value;
                        ptcu_pkg::CSR_COUNTEREN:
                            state_next.banks[bank_idx].counteren = item.write_value;
                        ptcu_pkg::CSR_SCRATCH:
                            state_next.banks[bank_idx].scratch = item.write_value;
                        ptcu_pkg::CSR_EPC:
                            state_next.banks[bank_idx].epc = item.write_value;
                        ptcu_pkg::CSR_CAUSE:
                            state_next.banks[bank_idx].cause = item.write_value;
                        ptcu_pkg::CSR_TVAL:
                            state_next.banks[bank_idx].tval = item.write_value;
                        ptcu_pkg::CSR_IP:        state_next.ip = item.write_value;
                        default:                 state_next = state_cur;
                    endcase
                end
            end
            ptcu_pkg::OP_SET_PENDING:
            begin
                // Only lines whose enable bit in ie is set are latched.
                if (state_cur.ie[ptcu_pkg::BIT_MEIP])
                begin
                    state_next.ip[ptcu_pkg::BIT_MEIP] = item.ext_irq;
                end
                if (state_cur.ie[ptcu_pkg::BIT_SEIP])
                begin
                    state_next.ip[ptcu_pkg::BIT_SEIP] = item.ext_irq;
                end
                if (state_cur.ie[ptcu_pkg::BIT_MTIP])
                begin
                    state_next.ip[ptcu_pkg::BIT_MTIP] = item.timer_irq;
                end
                if (state_cur.ie[ptcu_pkg::BIT_MSIP])
                begin
                    state_next.ip[ptcu_pkg::BIT_MSIP] = item.sw_irq;
                end
            end
            ptcu_pkg::OP_IRQ_CHECK:
            begin
                result.level_out = ptcu_pkg::LV_MACHINE;
                if (irq_live && (|(gate & serve_mask)))
                begin
                    result.irq_taken = 1'b1;
                    result.level_out = serve_level;
                end
            end
            ptcu_pkg::OP_EXC_DELEG:
            begin
                result.level_out = exc_level;
            end
            ptcu_pkg::OP_TRAP:
            begin
                if (bank_ok)
                begin
                    state_next.banks[bank_idx].epc = item.trap_is_irq ? item.current_pc :
                                                     item.current_pc - 32'd4;
                    state_next.banks[bank_idx].cause =
                        (item.trap_is_irq ? ptcu_pkg::CAUSE_INT_BIT : '0) |
                        {27'd0, item.cause_code};
                    state_next.banks[bank_idx].tval = item.trap_value;
                    if (item.level == ptcu_pkg::LV_MACHINE)
                    begin
                        state_next.status[ptcu_pkg::BIT_MPP_HI:ptcu_pkg::BIT_MPP_LO] =
                            item.previous_level;
                    end
                    else if (item.level == ptcu_pkg::LV_SUPER)
                    begin
                        state_next.status[ptcu_pkg::BIT_SPP] = item.previous_level[0];
                    end
                    // Save xIE into xPIE, then mask interrupts at this level.
                    state_next.status[pie_pos] = state_cur.status[ie_pos];
                    state_next.status[ie_pos]  = 1'b0;
                    result.result_value        = cur_bank.tvec;
                end
            end
            ptcu_pkg::OP_RETURN:
            begin
                if (bank_ok)
                begin
                    if (item.level == ptcu_pkg::LV_MACHINE)
                    begin
                        result.level_out =
                            state_cur.status[ptcu_pkg::BIT_MPP_HI:ptcu_pkg::BIT_MPP_LO];
                    end
                    else if (item.level == ptcu_pkg::LV_SUPER)
                    begin
                        result.level_out = {1'b0, state_cur.status[ptcu_pkg::BIT_SPP]};
                    end
                    state_next.status[ie_pos]  = state_cur.status[pie_pos];
                    state_next.status[pie_pos] = 1'b0;
                end
            end
            default:
            begin
                state_next = state_cur;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/privileged_trap_csr_unit_core.sv =====
// Top level of the privileged trap CSR unit: command register, state and result register.
`default_nettype none

// A command beat is taken on every clock edge where start is high; busy is
// always low, so one command can be issued in every cycle. The command is
// registered at the accepting edge, executed by a single pass of decode,
// delegation and update logic in the following cycle, and its result is
// registered at the next edge: done rises at that edge and stays high, with the
// result on the result ports, for exactly one cycle. State updates land on that
// same edge, so a back-to-back command sees the effect of the one before it. The
// receiver cannot stall the result, and done marks each result beat for one
// cycle only. The architectural state and the valid and done flags reset to
// zero.

module privileged_trap_csr_unit_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [2:0]  operation,
    input  wire  [1:0]  level,
    input  wire  [1:0]  previous_level,
    input  wire  [3:0]  csr_slot,
    input  wire  [31:0] write_value,
    input  wire         ext_irq,
    input  wire         timer_irq,
    input  wire         sw_irq,
    input  wire  [4:0]  cause_code,
    input  wire         trap_is_irq,
    input  wire  [31:0] current_pc,
    input  wire  [31:0] trap_value,
    output logic        done,
    output logic [31:0] result_value,
    output logic        irq_taken,
    output logic [1:0]  level_out
);

    ptcu_pkg::item_t      item_reg;
    logic                 item_valid_reg;
    ptcu_pkg::csr_state_t state_reg;
    ptcu_pkg::csr_state_t state_next;
    ptcu_pkg::result_t    result_next;
    ptcu_pkg::result_t    result_reg;
    logic                 done_reg;
    logic                 accept;

    // The unit takes a beat every cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Command register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.operation      <= operation;
            item_reg.level          <= level;
            item_reg.previous_level <= previous_level;
            item_reg.csr_slot       <= csr_slot;
            item_reg.write_value    <= write_value;
            item_reg.ext_irq        <= ext_irq;
            item_reg.timer_irq      <= timer_irq;
            item_reg.sw_irq         <= sw_irq;
            item_reg.cause_code     <= cause_code;
            item_reg.trap_is_irq    <= trap_is_irq;
            item_reg.current_pc     <= current_pc;
            item_reg.trap_value     <= trap_value;
        end
    end

    // Execution logic.
    ptcu_engine u_engine (
        .state_cur  (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (item_valid_reg)
        begin
            state_reg <= state_next;
        end
    end

    // Result register and strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done         = done_reg;
    assign result_value = result_reg.result_value;
    assign irq_taken    = result_reg.irq_taken;
    assign level_out    = result_reg.level_out;

    // Every accepted beat yields its result beat on done.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("accepted command produced no result beat");

    // A served interrupt is never assigned to the reserved level.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && irq_taken) |-> (level_out != ptcu_pkg::LV_RESERVED))
        else $error("interrupt served at reserved level");

    // Only reads and trap entries return data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !($past(item_reg.operation) == ptcu_pkg::OP_READ ||
                   $past(item_reg.operation) == ptcu_pkg::OP_TRAP))
        |-> (result_value == '0))
        else $error("nonzero data on a command that returns none");

    // Interrupt taken flag appears only for an interrupt check.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && irq_taken) |-> ($past(item_reg.operation) == ptcu_pkg::OP_IRQ_CHECK))
        else $error("irq_taken set on a command other than an interrupt check");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench of the privileged trap CSR unit: directed plan, then random beats.
`timescale 1ns / 100ps

module tb_top;
    import ptcu_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RANDOM_BEATS = 1400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    // The one operation code the unit leaves undefined.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // One row of the directed plan; want is used only where typed is set.
    typedef struct {
        item_t   cmd;
        bit      typed;
        result_t want;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    logic [31:0] result_value;
    logic        irq_taken;
    logic [1:0]  level_out;

    // Command beat presented on the input ports.
    item_t drv;

    // Shadow copy of the architectural state.
    logic [31:0] mdl_status;
    logic [31:0] mdl_ie;
    logic [31:0] mdl_ip;
    bank_t       mdl_bank [NUM_BANKS];

    result_t   csr_replies_due [$];
    plan_row_t plan_rows [$];
    int        fail_count;
    int        cycle_count;

    privileged_trap_csr_unit_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (drv.operation),
        .level          (drv.level),
        .previous_level (drv.previous_level),
        .csr_slot       (drv.csr_slot),
        .write_value    (drv.write_value),
        .ext_irq        (drv.ext_irq),
        .timer_irq      (drv.timer_irq),
        .sw_irq         (drv.sw_irq),
        .cause_code     (drv.cause_code),
        .trap_is_irq    (drv.trap_is_irq),
        .current_pc     (drv.current_pc),
        .trap_value     (drv.trap_value),
        .done           (done),
        .result_value   (result_value),
        .irq_taken      (irq_taken),
        .level_out      (level_out)
    );

    // Free-running clock.
    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Register bank of a privilege level; the reserved level has none.
    function automatic int bank_index(input logic [1:0] lvl);
        case (lvl)
            LV_USER:    return int'(BANK_USER);
            LV_SUPER:   return int'(BANK_SUPER);
            LV_MACHINE: return int'(BANK_MACHINE);
            default:    return -1;
        endcase
    endfunction

    // Reads one CSR slot of the shadow state and optionally overwrites it.
    function automatic logic [31:0] csr_access(input logic [1:0] lvl, input logic [3:0] idx,
                                               input bit wr, input logic [31:0] wval);
        int          b;
        logic [31:0] rd;
        b  = bank_index(lvl);
        rd = '0;
        if (b >= 0)
        begin
            case (idx)
                CSR_STATUS:    rd = mdl_status;
                CSR_IE:        rd = mdl_ie;
                CSR_IP:        rd = mdl_ip;
                CSR_ISA:       rd = mdl_bank[b].isa;
                CSR_EDELEG:    rd = mdl_bank[b].edeleg;
                CSR_IDELEG:    rd = mdl_bank[b].ideleg;
                CSR_TVEC:      rd = mdl_bank[b].tvec;
                CSR_COUNTEREN: rd = mdl_bank[b].counteren;
                CSR_SCRATCH:   rd = mdl_bank[b].scratch;
                CSR_EPC:       rd = mdl_bank[b].epc;
                CSR_CAUSE:     rd = mdl_bank[b].cause;
                CSR_TVAL:      rd = mdl_bank[b].tval;
                default:       rd = '0;
            endcase
            if (wr)
            begin
                case (idx)
                    CSR_STATUS:    mdl_status = wval;
                    CSR_IE:        mdl_ie = wval;
                    CSR_IP:        mdl_ip = wval;
                    CSR_ISA:       mdl_bank[b].isa = wval;
                    CSR_EDELEG:    mdl_bank[b].edeleg = wval;
                    CSR_IDELEG:    mdl_bank[b].ideleg = wval;
                    CSR_TVEC:      mdl_bank[b].tvec = wval;
                    CSR_COUNTEREN: mdl_bank[b].counteren = wval;
                    CSR_SCRATCH:   mdl_bank[b].scratch = wval;
                    CSR_EPC:       mdl_bank[b].epc = wval;
                    CSR_CAUSE:     mdl_bank[b].cause = wval;
                    CSR_TVAL:      mdl_bank[b].tval = wval;
                    default:       ;
                endcase
            end
        end
        return rd;
    endfunction

    // Walks from machine down to stop_at, skipping the reserved level, while the
    // delegation register of each level has the cause bit set. A result below
    // user (-1) means every tested level delegated.
    function automatic int delegation_target(input int stop_at, input bit on_irq,
                                             input logic [31:0] cbit);
        int          l;
        logic [31:0] dreg;
        for (l = int'(LV_MACHINE); l >= stop_at; l--)
        begin
            if (l == int'(LV_RESERVED))
                continue;
            dreg = on_irq ? mdl_bank[bank_index(2'(l))].ideleg
                          : mdl_bank[bank_index(2'(l))].edeleg;
            if ((dreg & cbit) == '0)
                break;
        end
        return l;
    endfunction

    // Executes one command on the shadow state and returns the reply it causes.
    function automatic result_t run_csr_command(input item_t c);
        result_t     r;
        int          b;
        int          dl;
        logic [31:0] cbit;
        logic [31:0] gate;
        logic [31:0] dmask;
        logic        bit_keep;
        r    = '0;
        b    = bank_index(c.level);
        cbit = 32'd1 << c.cause_code;
        case (c.operation)
            OP_READ:
                r.result_value = csr_access(c.level, c.csr_slot, 1'b0, '0);
            OP_WRITE:
                void'(csr_access(c.level, c.csr_slot, 1'b1, c.write_value));
            OP_SET_PENDING:
            begin
                // Only lines whose enable bit in ie is set are latched.
                if (mdl_ie[BIT_MEIP])
                    mdl_ip[BIT_MEIP] = c.ext_irq;
                if (mdl_ie[BIT_SEIP])
                    mdl_ip[BIT_SEIP] = c.ext_irq;
                if (mdl_ie[BIT_MTIP])
                    mdl_ip[BIT_MTIP] = c.timer_irq;
                if (mdl_ie[BIT_MSIP])
                    mdl_ip[BIT_MSIP] = c.sw_irq;
            end
            OP_IRQ_CHECK:
            begin
                r.level_out = LV_MACHINE;
                if (b >= 0 && (mdl_ip & cbit) != '0 && (mdl_ie & cbit) != '0)
                begin
                    dl    = delegation_target(int'(c.level), 1'b1, cbit);
                    gate  = (32'(GATE_BASE) >> (4 - int'(c.level))) & (mdl_status & 32'hF);
                    dmask = (dl < 0) ? '0 : (32'(SERVE_BASE) >> (3 - dl));
                    if ((gate & dmask) != '0)
                    begin
                        r.irq_taken = 1'b1;
                        r.level_out = 2'(dl);
                    end
                end
            end
            OP_EXC_DELEG:
            begin
                // Delegation saturates at user.
                dl = delegation_target(int'(LV_USER), 1'b0, cbit);
                r.level_out = (dl < 0) ? LV_USER : 2'(dl);
            end
            OP_TRAP:
            begin
                if (b >= 0)
                begin
                    mdl_bank[b].epc   = c.trap_is_irq ? c.current_pc : c.current_pc - 32'd4;
                    mdl_bank[b].cause = 32'(64'(c.trap_is_irq) << (XLEN_BITS - 1))
                                        | 32'(c.cause_code);
                    if (c.level == LV_MACHINE)
                        mdl_status[BIT_MPP_HI:BIT_MPP_LO] = c.previous_level;
                    else if (c.level == LV_SUPER)
                        mdl_status[BIT_SPP] = c.previous_level[0];
                    bit_keep = mdl_status[c.level];
                    mdl_status[4 + int'(c.level)] = bit_keep;
                    mdl_status[c.level] = 1'b0;
                    mdl_bank[b].tval = c.trap_value;
                    r.result_value   = mdl_bank[b].tvec;
                end
            end
            OP_RETURN:
            begin
                if (b >= 0)
                begin
                    if (c.level == LV_MACHINE)
                        r.level_out = mdl_status[BIT_MPP_HI:BIT_MPP_LO];
                    else if (c.level == LV_SUPER)
                        r.level_out = {1'b0, mdl_status[BIT_SPP]};
                    bit_keep = mdl_status[4 + int'(c.level)];
                    mdl_status[c.level] = bit_keep;
                    mdl_status[4 + int'(c.level)] = 1'b0;
                end
            end
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic item_t mk_cmd(input logic [2:0] op, input logic [1:0] lvl,
                                     input logic [1:0] prev, input logic [3:0] idx,
                                     input logic [31:0] wval, input logic [2:0] lines,
                                     input logic [4:0] code, input logic isint,
                                     input logic [31:0] pc, input logic [31:0] tval);
        item_t c;
        c.operation      = op;
        c.level          = lvl;
        c.previous_level = prev;
        c.csr_slot       = idx;
        c.write_value    = wval;
        c.ext_irq        = lines[2];
        c.timer_irq      = lines[1];
        c.sw_irq         = lines[0];
        c.cause_code     = code;
        c.trap_is_irq    = isint;
        c.current_pc     = pc;
        c.trap_value     = tval;
        return c;
    endfunction

    function automatic void add_row(input item_t c, input bit typed, input logic [31:0] rv,
                                    input logic tk, input logic [1:0] lv);
        plan_row_t row;
        row.cmd                = c;
        row.typed              = typed;
        row.want.result_value  = rv;
        row.want.irq_taken     = tk;
        row.want.level_out     = lv;
        plan_rows.push_back(row);
    endfunction

    // Presents one command beat after a gap and records its reply once taken.
    task automatic send_beat(input item_t c, input bit typed, input result_t want,
                             input int gap);
        result_t due;
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        drv   <= c;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        due = run_csr_command(c);
        csr_replies_due.push_back(typed ? want : due);
    endtask

    // Holds off the sender until every outstanding reply has arrived.
    task automatic drain_replies();
        @(negedge clk);
        start <= 1'b0;
        while (csr_replies_due.size() != 0)
            @(posedge clk);
    endtask

    // Reply checker: every done beat is compared with the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (csr_replies_due.size() == 0)
            begin
                $display("%0t: reply beat with none due: value=%h taken=%b level=%0d",
                         $time, result_value, irq_taken, level_out);
                fail_count++;
            end
            else
            begin
                want = csr_replies_due.pop_front();
                if (result_value !== want.result_value)
                begin
                    $display("%0t: result_value expected %h actual %h",
                             $time, want.result_value, result_value);
                    fail_count++;
                end
                if (irq_taken !== want.irq_taken)
                begin
                    $display("%0t: irq_taken expected %b actual %b",
                             $time, want.irq_taken, irq_taken);
                    fail_count++;
                end
                if (level_out !== want.level_out)
                begin
                    $display("%0t: level_out expected %0d actual %0d",
                             $time, want.level_out, level_out);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        item_t       c;
        result_t     no_want;
        int          pick;
        int          burst_left;
        bit          idle_on;
        logic [2:0]  op;
        logic [1:0]  lvl;
        logic [3:0]  idx;
        logic [31:0] wv;
        logic [4:0]  code;

        fail_count  = 0;
        cycle_count = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        drv         = '0;
        no_want     = '0;
        burst_left  = 0;
        idle_on     = 1'b0;
        mdl_status  = '0;
        mdl_ie      = '0;
        mdl_ip      = '0;
        foreach (mdl_bank[i])
            mdl_bank[i] = '0;

        // Hold reset, then release it away from the active edge.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed plan: reset values, reserved level and slots, pending latch, interrupt
        // checks, delegation, trap entry and return, and the unused operation code.
        add_row(mk_cmd(OP_READ, LV_MACHINE, LV_USER, CSR_STATUS, '0, 3'b000, 5'd0, 1'b0,
                       '0, '0), 1'b1, '0, 1'b0, LV_USER);
        add_row(mk_cmd(OP_WRITE, LV_MACHINE, LV_USER, CSR_TVEC, 32'hFFFF_FFFF, 3'b000, 5'd0,
                       1'b0, '0, '0), 1'b1, '0, 1'b0, LV_USER);
        add_row(mk_cmd(OP_READ, LV_MACHINE, LV_USER, CSR_TVEC, '0, 3'b000, 5'd0, 1'b0,
                       '0, '0), 1'b1, 32'hFFFF_FFFF, 1'b0, LV_USER);
        add_row(mk_cmd(OP_WRITE, LV_RESERVED, LV_USER, CSR_TVEC, 32'h5A5A_A5A5, 3'b000,
                       5'd0, 1'b0, '0, '0), 1'b1, '0, 1'b0, LV_USER);
        add_row(mk_cmd(OP_READ, LV_RESERVED, LV_USER, CSR_TVEC, '0, 3'b000, 5'd0, 1'b0,
                       '0, '0), 1'b1, '0, 1'b0, LV_USER);
        add_row(mk_cmd(OP_READ, LV_USER, LV_USER, 4'hF, '0, 3'b000, 5'd0, 1'b0, '0, '0),
                1'b1, '0, 1'b0, LV_USER);
        add_row(mk_cmd(OP_WRITE, LV_MACHINE, LV_USER, CSR_IE, 32'hFFFF_FFFF, 3'b000, 5'd0,
                       1'b0, '0, '0), 1'b1, '0, 1'b0, LV_USER);
        add_row(mk_cmd(OP_SET_PENDING, LV_MACHINE, LV_USER, CSR_STATUS, '0, 3'b111, 5'd0,
                       1'b0, '0, '0), 1'b1, '0, 1'b0, LV_USER);
        add_row(mk_cmd(OP_READ, LV_MACHINE, LV_USER, CSR_IP, '0, 3'b000, 5'd0, 1'b0, '0, '0),
                1'b0, '0, 1'b0, LV_USER);
        add_row(mk_cmd(OP_WRITE, LV_MACHINE, LV_USER, CSR_STATUS, 32'h0000_000F, 3'b000,
                       5'd0, 1'b0, '0, '0), 1'b1, '0, 1'b0, LV_USER);
        add_row(mk_cmd(OP_IRQ_CHECK, LV_USER, LV_USER, CSR_STATUS, '0, 3'b000, 5'(BIT_MEIP),
                       1'b0, '0, '0), 1'b0, '0, 1'b0, LV_USER);
        add_row(mk_cmd(OP_WRITE, LV_MACHINE, LV_USER, CSR_IDELEG, 32'hFFFF_FFFF, 3'b000,
                       5'd0, 1'b0, '0, '0), 1'b1, '0, 1'b0, LV_USER);
        add_row(mk_cmd(OP_IRQ_CHECK, LV_SUPER, LV_USER, CSR_STATUS, '0, 3'b000, 5'(BIT_SEIP),
                       1'b0, '0, '0), 1'b0, '0, 1'b0, LV_USER);
        add_row(mk_cmd(OP_EXC_DELEG, LV_USER, LV_USER, CSR_STATUS, '0, 3'b000, 5'd31, 1'b0,
                       '0, '0), 1'b1, '0, 1'b0, LV_MACHINE);
        add_row(mk_cmd(OP_WRITE, LV_MACHINE, LV_USER, CSR_EDELEG, 32'hFFFF_FFFF, 3'b000,
                       5'd0, 1'b0, '0, '0), 1'b1, '0, 1'b0, LV_USER);
        add_row(mk_cmd(OP_WRITE, LV_SUPER, LV_USER, CSR_EDELEG, 32'hFFFF_FFFF, 3'b000,
                       5'd0, 1'b0, '0, '0), 1'b1, '0, 1'b0, LV_USER);
        add_row(mk_cmd(OP_WRITE, LV_USER, LV_USER, CSR_EDELEG, 32'hFFFF_FFFF, 3'b000,
                       5'd0, 1'b0, '0, '0), 1'b1, '0, 1'b0, LV_USER);
        add_row(mk_cmd(OP_EXC_DELEG, LV_MACHINE, LV_USER, CSR_STATUS, '0, 3'b000, 5'd0, 1'b0,
                       '0, '0), 1'b1, '0, 1'b0, LV_USER);
        add_row(mk_cmd(OP_TRAP, LV_MACHINE, LV_MACHINE, CSR_STATUS, '0, 3'b000, 5'd31, 1'b0,
                       '0, 32'hFFFF_FFFF), 1'b1, 32'hFFFF_FFFF, 1'b0, LV_USER);
        add_row(mk_cmd(OP_READ, LV_MACHINE, LV_USER, CSR_EPC, '0, 3'b000, 5'd0, 1'b0,
                       '0, '0), 1'b1, 32'hFFFF_FFFC, 1'b0, LV_USER);
        add_row(mk_cmd(OP_TRAP, LV_SUPER, LV_SUPER, CSR_STATUS, '0, 3'b000, 5'd31, 1'b1,
                       32'hFFFF_FFFF, '0), 1'b0, '0, 1'b0, LV_USER);
        add_row(mk_cmd(OP_RETURN, LV_MACHINE, LV_USER, CSR_STATUS, '0, 3'b000, 5'd0, 1'b0,
                       '0, '0), 1'b0, '0, 1'b0, LV_USER);
        add_row(mk_cmd(OP_TRAP, LV_RESERVED, LV_MACHINE, CSR_STATUS, '0, 3'b111, 5'd31, 1'b1,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1, '0, 1'b0, LV_USER);
        add_row(mk_cmd(OP_RETURN, LV_RESERVED, LV_USER, CSR_STATUS, '0, 3'b000, 5'd0, 1'b0,
                       '0, '0), 1'b1, '0, 1'b0, LV_USER);
        add_row(mk_cmd(OP_IRQ_CHECK, LV_RESERVED, LV_USER, CSR_STATUS, '0, 3'b000,
                       5'(BIT_MEIP), 1'b0, '0, '0), 1'b1, '0, 1'b0, LV_MACHINE);
        add_row(mk_cmd(OP_UNUSED, LV_MACHINE, LV_MACHINE, CSR_TVEC, 32'hFFFF_FFFF, 3'b111,
                       5'd31, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1, '0, 1'b0, LV_USER);

        foreach (plan_rows[i])
            send_beat(plan_rows[i].cmd, plan_rows[i].typed, plan_rows[i].want,
                      $urandom_range(0, 5));

        // Let the pipeline empty completely before the random part.
        drain_replies();

        // Random part: writes and traps build up state that checks and returns
        // then observe; causes lean toward the implemented interrupt bits.
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (burst_left == 0)
            begin
                idle_on    = ($urandom_range(0, 3) != 0);
                burst_left = $urandom_range(16, 64);
            end
            burst_left--;

            pick = $urandom_range(0, 99);
            if (pick < 15)
                op = OP_READ;
            else if (pick < 40)
                op = OP_WRITE;
            else if (pick < 50)
                op = OP_SET_PENDING;
            else if (pick < 70)
                op = OP_IRQ_CHECK;
            else if (pick < 78)
                op = OP_EXC_DELEG;
            else if (pick < 90)
                op = OP_TRAP;
            else if (pick < 99)
                op = OP_RETURN;
            else
                op = OP_UNUSED;

            case ($urandom_range(0, 9))
                0:       lvl = LV_RESERVED;
                1, 2, 3: lvl = LV_MACHINE;
                4, 5, 6: lvl = LV_SUPER;
                default: lvl = LV_USER;
            endcase

            if ($urandom_range(0, 7) == 0)
                idx = 4'($urandom_range(12, 15));
            else
                idx = 4'($urandom_range(0, 11));

            case ($urandom_range(0, 5))
                0:       wv = 32'hFFFF_FFFF;
                1:       wv = '0;
                2:       wv = $urandom & 32'h0000_1FFF;
                default: wv = $urandom;
            endcase

            case ($urandom_range(0, 7))
                0:       code = 5'(BIT_MSIP);
                1:       code = 5'(BIT_MTIP);
                2:       code = 5'(BIT_SEIP);
                3:       code = 5'(BIT_MEIP);
                default: code = 5'($urandom_range(0, 31));
            endcase

            c = mk_cmd(op, lvl, 2'($urandom_range(0, 3)), idx, wv, 3'($urandom_range(0, 7)),
                       code, 1'($urandom_range(0, 1)), $urandom, $urandom);
            send_beat(c, 1'b0, no_want, idle_on ? $urandom_range(0, 5) : 0);

            if (n % 350 == 349)
                drain_replies();
        end

        // Wait for the last replies, then keep watching for stray ones.
        drain_replies();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ptcu_pkg.sv
sv/ptcu_engine.sv
sv/privileged_trap_csr_unit_core.sv
tb/tb_top.sv
